### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DVP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define DVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dvp_pkg.sv
// Types and codes of the deadlock victim preemptor.
`default_nettype none
package dvp_pkg;

  typedef enum logic [2:0] {
    OP_DEF_PROC = 3'd0,
    OP_DEF_RES  = 3'd1,
    OP_SET_HELD = 3'd2,
    OP_DROP_HELD = 3'd3,
    OP_SET_WAIT = 3'd4,
    OP_RECOVER  = 3'd5
  } dvp_op_t;

  typedef enum logic [2:0] {
    ST_ACK        = 3'd0,
    ST_PREEMPT    = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_NO_MEMBERS = 3'd3,
    ST_NO_VICTIM  = 3'd4
  } dvp_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_G_RD,
    S_G_EV,
    S_B_RD,
    S_B_EV,
    S_B_CMP,
    S_C_RD,
    S_C_EV,
    S_FIN,
    S_REPORT
  } dvp_state_t;

  localparam int unsigned FREE_BITS = 16;

endpackage
`default_nettype wire

### rtl/dvp_if.sv
// Command and result channel interfaces.
`default_nettype none
interface dvp_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [3:0]        process_id;
  logic [3:0]        resource_id;
  logic [15:0]       amount;
  logic signed [7:0] priority_value;
  modport source(output valid, op, process_id, resource_id, amount, priority_value,
                 input ready);
  modport sink(input valid, op, process_id, resource_id, amount, priority_value,
               output ready);
endinterface

interface dvp_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] victim_id;
  logic [3:0] freed_resource;
  logic [7:0] freed_count;
  logic       last;
  modport source(output valid, status, victim_id, freed_resource, freed_count, last,
                 input ready);
  modport sink(input valid, status, victim_id, freed_resource, freed_count, last,
               output ready);
endinterface
`default_nettype wire

### rtl/deadlock_victim_preemptor.sv
// Deadlock victim preemptor: tables, recovery sequencer and result register.
//
//   channel  dir  transfer carries
//   cmd      in   op, process_id, resource_id, amount, priority_value
//   rsp      out  status, victim_id, freed_resource, freed_count, last
//
// Set-up ops return one ack transfer.
// Recover: gather walks every resource, a read and an evaluate state per process,
//   twice over present resources that have a waiter; scoring reads the whole row
//   of each present candidate, then compares; preemption walks the victim row.
//   All steps share one read port of the pair tables.
// After rst a clearing pass over every pair zeroes the pair tables; cmd.ready
//   stays low until it is done.
// A stalled rsp holds its result; the walk waits only when a second result
//   is pending behind it.
`default_nettype none
module deadlock_victim_preemptor #(
  parameter int NUM_PROCESSES = 16,
  parameter int NUM_RESOURCES = 16,
  parameter int COUNT_BITS    = 8
) (
  input  wire     clk,
  input  wire     rst,
  dvp_cmd_if.sink cmd,
  dvp_rsp_if.source rsp
);
  import dvp_pkg::*;

  localparam int PAIRS = NUM_PROCESSES * NUM_RESOURCES;
  localparam int PB    = $clog2(NUM_PROCESSES);
  localparam int RB    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int PRW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  // cost = entries + counts - priority, signed, with headroom
  localparam int CW    = COUNT_BITS + RB + 10;

  // Tables: presence bits in flops, everything else in memories.
  logic [COUNT_BITS:0]  held_mem [PAIRS];   // {entry, count}
  logic                 wait_mem [PAIRS];
  logic [7:0]           prio_mem [NUM_PROCESSES];
  logic [FREE_BITS-1:0] free_mem [NUM_RESOURCES];

  logic [NUM_PROCESSES-1:0] proc_present;
  logic [NUM_RESOURCES-1:0] res_present;

  // Sequencer registers
  dvp_state_t state, state_next;
  logic [PRW-1:0] clr_idx;
  logic [PB-1:0]  pc;
  logic [RB-1:0]  rc;
  logic           pass;      // 0: waiter scan, 1: holder scan
  logic           waited;
  logic           any_wait;
  logic [NUM_PROCESSES-1:0] cand;
  logic [PB-1:0]  victim;
  logic           found;
  logic signed [CW-1:0] best;
  logic signed [CW-1:0] acc;
  logic           pend_valid;
  logic [RB-1:0]  pend_res;
  logic [COUNT_BITS-1:0] pend_cnt;
  dvp_status_t    rep_status;

  // Result register
  logic        out_valid;
  dvp_status_t out_status;
  logic [3:0]  out_victim;
  logic [3:0]  out_res;
  logic [7:0]  out_cnt;
  logic        out_last;

  // Registered read data
  logic [COUNT_BITS:0]  held_rd;
  logic                 wait_rd;
  logic [7:0]           prio_rd;
  logic [FREE_BITS-1:0] free_rd;

  // Write ports
  logic                 hw_en, ww_en, pw_en, fw_en;
  logic [PRW-1:0]       hw_addr;
  logic [COUNT_BITS:0]  hw_data;
  logic                 ww_data;
  logic [PB-1:0]        pw_addr;
  logic [RB-1:0]        fw_addr;
  logic [FREE_BITS-1:0] fw_data;

  // Result load
  logic        out_load;
  dvp_status_t ld_status;
  logic [3:0]  ld_victim;
  logic [3:0]  ld_res;
  logic [7:0]  ld_cnt;
  logic        ld_last;

  logic           out_free;
  logic           accept;
  logic           pok, rok;
  logic [PRW-1:0] cmd_pair;
  logic [PRW-1:0] pair_ra;
  logic           p_last, r_last, clr_last;
  logic           any_now, waited_now;
  logic           held_entry;
  logic [COUNT_BITS-1:0] held_cnt;
  logic           cand_ok;
  logic           c_go;
  logic signed [CW-1:0] cost;
  logic           better;
  logic [FREE_BITS:0] free_sum;

  assign out_free   = !out_valid || rsp.ready;
  assign cmd.ready  = (state == S_IDLE) && out_free;
  assign accept     = cmd.valid && cmd.ready;
  assign pok        = 32'(cmd.process_id) < NUM_PROCESSES;
  assign rok        = 32'(cmd.resource_id) < NUM_RESOURCES;
  assign cmd_pair   = PRW'(32'(cmd.process_id) * NUM_RESOURCES + 32'(cmd.resource_id));
  assign pair_ra    = PRW'(32'(pc) * NUM_RESOURCES + 32'(rc));
  assign p_last     = 32'(pc) == NUM_PROCESSES - 1;
  assign r_last     = 32'(rc) == NUM_RESOURCES - 1;
  assign clr_last   = 32'(clr_idx) == PAIRS - 1;
  assign held_entry = held_rd[COUNT_BITS];
  assign held_cnt   = held_rd[COUNT_BITS-1:0];
  assign any_now    = any_wait || (!pass && wait_rd);
  assign waited_now = waited || wait_rd;
  assign cand_ok    = cand[pc] && proc_present[pc];
  assign c_go       = !held_entry || !pend_valid || out_free;
  assign cost       = acc - {{(CW-8){prio_rd[7]}}, prio_rd};
  assign better     = !found || (cost < best);
  assign free_sum   = {1'b0, free_rd} + (FREE_BITS+1)'(held_cnt);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept && cmd.op == OP_RECOVER) state_next = S_G_RD;
      end
      S_G_RD: state_next = S_G_EV;
      S_G_EV: begin
        state_next = S_G_RD;
        if (p_last && r_last && (pass || !(waited_now && res_present[rc]))) begin
          state_next = any_now ? S_B_RD : S_REPORT;
        end
      end
      S_B_RD: begin
        if (cand_ok) begin
          state_next = S_B_EV;
        end else if (p_last) begin
          state_next = found ? S_C_RD : S_REPORT;
        end
      end
      S_B_EV: state_next = r_last ? S_B_CMP : S_B_RD;
      S_B_CMP: begin
        if (p_last) state_next = S_C_RD;
        else state_next = S_B_RD;
      end
      S_C_RD: state_next = S_C_EV;
      S_C_EV: begin
        if (c_go) state_next = r_last ? S_FIN : S_C_RD;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      S_REPORT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory writes and result loads
  always_comb begin
    hw_en = 1'b0; hw_addr = pair_ra; hw_data = '0;
    ww_en = 1'b0; ww_data = 1'b0;
    pw_en = 1'b0; pw_addr = PB'(cmd.process_id);
    fw_en = 1'b0; fw_addr = rc; fw_data = '0;
    out_load = 1'b0; ld_status = ST_ACK; ld_victim = '0; ld_res = '0;
    ld_cnt = '0; ld_last = 1'b1;
    case (state)
      S_CLEAR: begin
        hw_en = 1'b1; ww_en = 1'b1; hw_addr = clr_idx;
      end
      S_IDLE: begin
        if (accept) begin
          hw_addr = cmd_pair;
          if (cmd.op != OP_RECOVER) out_load = 1'b1;
          case (cmd.op)
            OP_DEF_PROC: pw_en = pok;
            OP_DEF_RES: begin
              fw_en = rok; fw_addr = RB'(cmd.resource_id); fw_data = cmd.amount;
            end
            OP_SET_HELD: begin
              hw_en = pok && rok; hw_data = {1'b1, cmd.amount[COUNT_BITS-1:0]};
            end
            OP_DROP_HELD: hw_en = pok && rok;
            OP_SET_WAIT: begin
              ww_en = pok && rok; ww_data = cmd.amount[0];
            end
            default: ;
          endcase
        end
      end
      S_C_EV: begin
        if (c_go) begin
          hw_en = 1'b1; ww_en = 1'b1;
          if (held_entry) begin
            fw_en   = res_present[rc];
            fw_data = free_sum[FREE_BITS] ? '1 : free_sum[FREE_BITS-1:0];
            if (pend_valid) begin
              out_load = 1'b1; ld_status = ST_PREEMPT; ld_victim = 4'(victim);
              ld_res = 4'(pend_res); ld_cnt = 8'(pend_cnt); ld_last = 1'b0;
            end
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1; ld_victim = 4'(victim);
          if (pend_valid) begin
            ld_status = ST_PREEMPT; ld_res = 4'(pend_res); ld_cnt = 8'(pend_cnt);
          end else begin
            ld_status = ST_EMPTY;
          end
        end
      end
      S_REPORT: begin
        if (out_free) begin
          out_load = 1'b1; ld_status = rep_status;
        end
      end
      default: ;
    endcase
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (hw_en) held_mem[hw_addr] <= hw_data;
    if (ww_en) wait_mem[hw_addr] <= ww_data;
    if (pw_en) prio_mem[pw_addr] <= cmd.priority_value;
    if (fw_en) free_mem[fw_addr] <= fw_data;
    held_rd <= held_mem[pair_ra];
    wait_rd <= wait_mem[pair_ra];
    prio_rd <= prio_mem[pc];
    free_rd <= free_mem[rc];
  end

  // Control and sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      proc_present <= '0;
      res_present  <= '0;
      out_valid    <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_IDLE: begin
          if (accept) begin
            if (cmd.op == OP_DEF_PROC && pok) proc_present[PB'(cmd.process_id)] <= 1'b1;
            if (cmd.op == OP_DEF_RES && rok) res_present[RB'(cmd.resource_id)] <= 1'b1;
            pc <= '0; rc <= '0; pass <= 1'b0; waited <= 1'b0; any_wait <= 1'b0;
            cand <= '0; found <= 1'b0; acc <= '0; pend_valid <= 1'b0;
          end
        end
        S_G_EV: begin
          if (!pass) begin
            if (wait_rd) begin
              cand[pc] <= 1'b1; waited <= 1'b1; any_wait <= 1'b1;
            end
          end else if (proc_present[pc] && held_entry && held_cnt != '0) begin
            cand[pc] <= 1'b1;
          end
          if (p_last) begin
            pc <= '0;
            if (!pass && waited_now && res_present[rc]) begin
              pass <= 1'b1;
            end else begin
              pass <= 1'b0; waited <= 1'b0;
              if (r_last) begin
                rc <= '0;
                rep_status <= ST_NO_MEMBERS;
              end else begin
                rc <= rc + 1'b1;
              end
            end
          end else begin
            pc <= pc + 1'b1;
          end
        end
        S_B_RD: begin
          if (!cand_ok) begin
            if (p_last) begin
              pc <= victim; rep_status <= ST_NO_VICTIM;
            end else begin
              pc <= pc + 1'b1;
            end
          end
        end
        S_B_EV: begin
          if (held_entry) acc <= acc + CW'(held_cnt) + 1'b1;
          rc <= r_last ? '0 : rc + 1'b1;
        end
        S_B_CMP: begin
          acc <= '0;
          if (better) begin
            best <= cost; victim <= pc; found <= 1'b1;
          end
          if (p_last) pc <= better ? pc : victim;
          else pc <= pc + 1'b1;
        end
        S_C_EV: begin
          if (c_go) begin
            if (held_entry) begin
              pend_valid <= 1'b1; pend_res <= rc; pend_cnt <= held_cnt;
            end
            rc <= r_last ? '0 : rc + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= ld_status;
      out_victim <= ld_victim;
      out_res    <= ld_res;
      out_cnt    <= ld_cnt;
      out_last   <= ld_last;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.victim_id      = out_victim;
  assign rsp.freed_resource = out_res;
  assign rsp.freed_count    = out_cnt;
  assign rsp.last           = out_last;

endmodule
`default_nettype wire

### rtl/dvp_checker.sv
// Port-level checks of the deadlock victim preemptor, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module dvp_checker (
  input wire       clk,
  input wire       rst,
  input wire       cmd_valid,
  input wire       cmd_ready,
  input wire       rsp_valid,
  input wire       rsp_ready,
  input wire [2:0] status,
  input wire [3:0] victim_id,
  input wire [3:0] freed_resource,
  input wire [7:0] freed_count,
  input wire       last
);
  import dvp_pkg::*;

  logic rsp_xfer;
  assign rsp_xfer = rsp_valid && rsp_ready;

  // stalled result holds
  `DVP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(victim_id) && $stable(freed_resource) && $stable(freed_count) && $stable(last), "result changed while stalled")

  // only a preempted entry can be followed by more results
  `DVP_ASSERT_NOW(a_single_last, rsp_valid && status != ST_PREEMPT, last, "single result without last")

  // no command is taken while a recovery still has results to give
  `DVP_ASSERT_NOW(a_no_cmd_mid, rsp_valid && !last, !(cmd_valid && cmd_ready), "command taken mid recovery")

  // resource and count are zero outside a preemption result; so is the victim, but on an empty result
  `DVP_ASSERT_NOW(a_zero_fields, rsp_xfer && status != ST_PREEMPT, freed_resource == 4'd0 && freed_count == 8'd0 && (status == ST_EMPTY || victim_id == 4'd0), "nonzero idle fields")

endmodule

bind deadlock_victim_preemptor dvp_checker u_dvp_checker (
  .clk(clk),
  .rst(rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .status(rsp.status),
  .victim_id(rsp.victim_id),
  .freed_resource(rsp.freed_resource),
  .freed_count(rsp.freed_count),
  .last(rsp.last)
);
`default_nettype wire

### bench/deadlock_victim_preemptor_tb.sv
// Testbench for the deadlock victim preemptor: directed table plus random ops.
`timescale 1ns / 1ps
`default_nettype none
module deadlock_victim_preemptor_tb;
  import dvp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  dvp_cmd_if cmd ();
  dvp_rsp_if rsp ();

  deadlock_victim_preemptor uut (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  // One expected result beat.
  typedef struct packed {
    logic [2:0] status;
    logic [3:0] victim_id;
    logic [3:0] freed_resource;
    logic [7:0] freed_count;
    logic       last;
  } beat_t;

  // Directed row: the command, plus an optional typed-in answer.
  typedef struct packed {
    logic [2:0]        op;
    logic [3:0]        pid;
    logic [3:0]        rid;
    logic [15:0]       amt;
    logic signed [7:0] prio;
    logic              fixed;
    logic [2:0]        fixed_status;
  } row_t;

  // Shadow copy of the block's tables.
  logic              proc_on [16];
  logic signed [7:0] proc_prio [16];
  logic              res_on [16];
  logic [15:0]       free_cnt [16];
  logic              held_on [16][16];
  logic [7:0]        held_cnt [16][16];
  logic              waits [16][16];   // [resource][process]

  beat_t pending_beats[$];
  int errors = 0;
  int beats_seen = 0;
  int recovers_sent = 0;
  int preempts_seen = 0;
  bit hold_rsp = 1'b0;   // long receiver hold-off
  bit no_idle = 1'b0;    // final stretch with no idling

  task automatic report(input string what, input beat_t got, input beat_t want);
    errors++;
    $display("mismatch %s: got st=%0d v=%0d r=%0d c=%0d l=%0d want st=%0d v=%0d r=%0d c=%0d l=%0d",
             what, got.status, got.victim_id, got.freed_resource, got.freed_count, got.last,
             want.status, want.victim_id, want.freed_resource, want.freed_count, want.last);
  endtask

  function automatic beat_t mk(input logic [2:0] st, input logic [3:0] v,
                               input logic [3:0] r, input logic [7:0] c, input logic l);
    beat_t b;
    b.status = st; b.victim_id = v; b.freed_resource = r;
    b.freed_count = c; b.last = l;
    return b;
  endfunction

  function automatic void clear_tables();
    for (int p = 0; p < 16; p++) begin
      proc_on[p] = 1'b0; proc_prio[p] = '0; res_on[p] = 1'b0; free_cnt[p] = '0;
      for (int r = 0; r < 16; r++) begin
        held_on[p][r] = 1'b0; held_cnt[p][r] = '0; waits[p][r] = 1'b0;
      end
    end
  endfunction

  // Victim selection and preemption; queues the result beats.
  task automatic predict_recovery();
    bit cand [16];
    bit any_waiter;
    bit waited;
    int victim;
    longint best, cost;
    int n;
    int unsigned sum;
    any_waiter = 0; victim = -1; best = 0; n = 0;
    for (int p = 0; p < 16; p++) cand[p] = 0;
    for (int r = 0; r < 16; r++) begin
      waited = 0;
      for (int p = 0; p < 16; p++)
        if (waits[r][p]) begin
          cand[p] = 1; waited = 1; any_waiter = 1;
        end
      if (waited && res_on[r])
        for (int p = 0; p < 16; p++)
          if (proc_on[p] && held_on[p][r] && held_cnt[p][r] != 0) cand[p] = 1;
    end
    if (!any_waiter) begin
      pending_beats.push_back(mk(ST_NO_MEMBERS, 0, 0, 0, 1));
      return;
    end
    for (int p = 0; p < 16; p++) begin
      if (!cand[p] || !proc_on[p]) continue;
      cost = 0;
      for (int r = 0; r < 16; r++)
        if (held_on[p][r]) cost += 1 + held_cnt[p][r];
      cost -= proc_prio[p];
      if (victim < 0 || cost < best) begin
        best = cost; victim = p;
      end
    end
    if (victim < 0) begin
      pending_beats.push_back(mk(ST_NO_VICTIM, 0, 0, 0, 1));
      return;
    end
    for (int r = 0; r < 16; r++) begin
      if (!held_on[victim][r]) continue;
      if (res_on[r]) begin
        sum = free_cnt[r] + held_cnt[victim][r];
        free_cnt[r] = (sum > 16'hFFFF) ? 16'hFFFF : sum[15:0];
      end
      pending_beats.push_back(mk(ST_PREEMPT, victim[3:0], r[3:0], held_cnt[victim][r], 0));
      n++;
      held_on[victim][r] = 1'b0; held_cnt[victim][r] = '0;
    end
    if (n == 0) pending_beats.push_back(mk(ST_EMPTY, victim[3:0], 0, 0, 1));
    else pending_beats[$].last = 1'b1;
    for (int r = 0; r < 16; r++) waits[r][victim] = 1'b0;
  endtask

  // Applies one accepted command to the shadow tables.
  task automatic predict_command(input row_t c);
    case (c.op)
      OP_RECOVER: begin
        predict_recovery();
        return;
      end
      OP_DEF_PROC: begin
        proc_on[c.pid] = 1'b1; proc_prio[c.pid] = c.prio;
      end
      OP_DEF_RES: begin
        res_on[c.rid] = 1'b1; free_cnt[c.rid] = c.amt;
      end
      OP_SET_HELD: begin
        held_on[c.pid][c.rid] = 1'b1; held_cnt[c.pid][c.rid] = c.amt[7:0];
      end
      OP_DROP_HELD: begin
        held_on[c.pid][c.rid] = 1'b0; held_cnt[c.pid][c.rid] = '0;
      end
      OP_SET_WAIT: waits[c.rid][c.pid] = c.amt[0];
      default: ;  // unknown ops only acknowledge
    endcase
    pending_beats.push_back(mk(ST_ACK, 0, 0, 0, 1));
  endtask

  // ---------------------------------------------------------------- sender
  int idle_left_cmd = 0;

  function automatic row_t rr(input logic [2:0] op, input logic [3:0] p, input logic [3:0] r,
                              input logic [15:0] a, input logic signed [7:0] pr,
                              input logic fx, input logic [2:0] fs);
    row_t x;
    x.op = op; x.pid = p; x.rid = r; x.amt = a; x.prio = pr;
    x.fixed = fx; x.fixed_status = fs;
    return x;
  endfunction

  // Sends one command: applies random idle bursts, waits for the transfer.
  task automatic send(input row_t c);
    if (!no_idle && idle_left_cmd == 0 && $urandom_range(0, 7) == 0)
      idle_left_cmd = $urandom_range(1, 16);
    while (idle_left_cmd > 0) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
      idle_left_cmd--;
    end
    cmd.valid <= 1'b1;
    cmd.op <= c.op; cmd.process_id <= c.pid; cmd.resource_id <= c.rid;
    cmd.amount <= c.amt; cmd.priority_value <= c.prio;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    // transfer happened at this edge; predict before anything else can be sampled
    if (c.op == OP_RECOVER) recovers_sent++;
    if (c.fixed) pending_beats.push_back(mk(c.fixed_status, 0, 0, 0, 1));
    predict_command(c);
    if (c.fixed) void'(pending_beats.pop_back());  // typed-in row already queued
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  // Random command, mostly well-formed deadlock scenarios on a small id set.
  function automatic row_t rand_cmd();
    int k;
    logic [2:0] op;
    k = $urandom_range(0, 99);
    if (k < 12) op = OP_DEF_PROC;
    else if (k < 22) op = OP_DEF_RES;
    else if (k < 50) op = OP_SET_HELD;
    else if (k < 58) op = OP_DROP_HELD;
    else if (k < 80) op = OP_SET_WAIT;
    else if (k < 96) op = OP_RECOVER;
    else op = 3'($urandom_range(6, 7));
    return rr(op,
              ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5)),
              ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4)),
              (op == OP_SET_WAIT) ? 16'($urandom_range(0, 3) != 0) :
              (($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40))),
              8'($urandom), 1'b0, ST_ACK);
  endfunction

  row_t directed [$];

  initial begin
    cmd.valid = 1'b0; cmd.op = '0; cmd.process_id = '0; cmd.resource_id = '0;
    cmd.amount = '0; cmd.priority_value = '0;
    rsp.ready = 1'b0;
    clear_tables();

    // Directed table: fixed answers where obvious, else the shadow model.
    directed = '{
      rr(OP_RECOVER,   0,  0, 0,       0,    1, ST_NO_MEMBERS),  // empty tables
      rr(OP_SET_WAIT,  3,  2, 1,       0,    1, ST_ACK),         // waiter not present
      rr(OP_RECOVER,   0,  0, 0,       0,    1, ST_NO_VICTIM),
      rr(OP_DEF_PROC,  0,  0, 0,       -128, 1, ST_ACK),
      rr(OP_DEF_PROC,  15, 0, 0,       127,  1, ST_ACK),
      rr(OP_DEF_PROC,  3,  0, 0,       0,    1, ST_ACK),
      rr(OP_DEF_RES,   0,  0, 16'hFFFF, 0,   1, ST_ACK),
      rr(OP_DEF_RES,   15, 15, 16'hFFF0, 0,  1, ST_ACK),
      rr(OP_DEF_RES,   0,  2, 0,       0,    1, ST_ACK),
      rr(OP_SET_HELD,  15, 15, 16'hFFFF, 0,  1, ST_ACK),         // count keeps low byte
      rr(OP_SET_HELD,  15, 0, 16'h0100, 0,   1, ST_ACK),         // zero-count entry
      rr(OP_SET_HELD,  15, 2, 5,       0,    1, ST_ACK),
      rr(OP_SET_HELD,  0,  2, 7,       0,    1, ST_ACK),
      rr(OP_SET_WAIT,  15, 15, 16'hFFFE, 0,  1, ST_ACK),         // bit 0 clear
      rr(3'd6,         1,  1, 1,       1,    1, ST_ACK),         // unknown ops
      rr(3'd7,         1,  1, 1,       1,    1, ST_ACK),
      rr(OP_RECOVER,   0,  0, 0,       0,    0, ST_ACK),         // holders of waited resource join the candidates
      rr(OP_RECOVER,   0,  0, 0,       0,    0, ST_ACK),
      rr(OP_SET_WAIT,  15, 15, 1,      0,    1, ST_ACK),
      rr(OP_RECOVER,   0,  0, 0,       0,    0, ST_ACK),         // saturating free count
      rr(OP_DROP_HELD, 0,  2, 0,       0,    1, ST_ACK),
      rr(OP_SET_WAIT,  0,  9, 1,       0,    1, ST_ACK),
      rr(OP_RECOVER,   0,  0, 0,       0,    0, ST_ACK),         // victim held nothing
      rr(OP_RECOVER,   0,  0, 0,       0,    0, ST_ACK)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send(directed[i]);
    drain();  // sender pauses until every expected result is back

    // Receiver holds off while the sender keeps offering.
    hold_rsp = 1'b1;
    for (int i = 0; i < 60; i++) send(rand_cmd());
    drain();
    for (int i = 0; i < 40; i++) send(rand_cmd());
    no_idle = 1'b1;
    for (int i = 0; i < 30; i++) send(rand_cmd());
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d recoveries, %0d preempted entries, %0d result transfers",
             recovers_sent, preempts_seen, beats_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  int idle_left_rsp = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_rsp && !hold_done) begin
      rsp.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles >= 400) hold_done <= 1'b1;
    end else if (no_idle) begin
      rsp.ready <= 1'b1;
    end else if (idle_left_rsp > 0) begin
      rsp.ready <= 1'b0;
      idle_left_rsp <= idle_left_rsp - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      rsp.ready <= 1'b0;
      idle_left_rsp <= $urandom_range(0, 15);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    beat_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got = mk(rsp.status, rsp.victim_id, rsp.freed_resource, rsp.freed_count, rsp.last);
      beats_seen++;
      if (got.status == ST_PREEMPT) preempts_seen++;
      if (pending_beats.size() == 0) begin
        report("unexpected result", got, '0);
      end else begin
        if (got != pending_beats[0]) report("field", got, pending_beats[0]);
        void'(pending_beats.pop_front());
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  int quiet = 0;
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
`default_nettype wire
